// ----- design/two_axis_waypoint_sequencer_macros.svh -----
// Assertion helpers shared by the sequencer top level.
`ifndef TWO_AXIS_WAYPOINT_SEQUENCER_MACROS_SVH
`define TWO_AXIS_WAYPOINT_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TWS_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sequencer check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TWS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sequencer check failed");

`endif

// ----- design/tws_pkg.sv -----
`timescale 1ns / 1ps
package tws_pkg;

   localparam int OP_W      = 3;
   localparam int POS_W     = 32;
   localparam int SPD_W     = 16;
   localparam int LIM_W     = 32;
   localparam int ELAPSED_W = 16;
   localparam int STATUS_W  = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 3'd0,
      OP_CLEAR = 3'd1,
      OP_START = 3'd2,
      OP_STOP  = 3'd3,
      OP_POLL  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_APPENDED = 3'd1,
      ST_FULL     = 3'd2,
      ST_BUSY     = 3'd3,
      ST_FAULT    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_CMD  = 2'd1,
      PH_WAIT = 2'd2
   } phase_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic                          load;    // take the request transaction
      logic                          commit;  // update state, load the result
   } ctl_cmd_type;

   typedef struct packed {
      logic                          out_blocked;  // result register still held
   } ctl_sts_type;

   typedef struct packed {
      logic [OP_W-1:0]               operation;
      logic signed [POS_W-1:0]       target_x;
      logic signed [POS_W-1:0]       target_y;
      logic [SPD_W-1:0]              speed_x;
      logic [SPD_W-1:0]              speed_y;
      logic [LIM_W-1:0]              time_limit;
      logic [ELAPSED_W-1:0]          elapsed;
      logic signed [POS_W-1:0]       measured_x;
      logic signed [POS_W-1:0]       measured_y;
      logic                          read_fault;
   } req_item_type;

   typedef struct packed {
      logic                          move_cmd;
      logic signed [POS_W-1:0]       move_x;
      logic signed [POS_W-1:0]       move_y;
      logic [SPD_W-1:0]              move_speed_x;
      logic [SPD_W-1:0]              move_speed_y;
      logic                          halt_cmd;
      logic                          run_done;
      logic [STATUS_W-1:0]           status;
   } rsp_item_type;

endpackage

// ----- design/tws_if.sv -----
`timescale 1ns / 1ps
interface tws_req_if
   import tws_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic signed [POS_W-1:0] target_x;
   logic signed [POS_W-1:0] target_y;
   logic [SPD_W-1:0]        speed_x;
   logic [SPD_W-1:0]        speed_y;
   logic [LIM_W-1:0]        time_limit;
   logic [ELAPSED_W-1:0]    elapsed;
   logic signed [POS_W-1:0] measured_x;
   logic signed [POS_W-1:0] measured_y;
   logic                    read_fault;

   modport source (
      output valid, operation, target_x, target_y, speed_x, speed_y, time_limit,
             elapsed, measured_x, measured_y, read_fault,
      input  ready
   );
   modport sink (
      input  valid, operation, target_x, target_y, speed_x, speed_y, time_limit,
             elapsed, measured_x, measured_y, read_fault,
      output ready
   );
endinterface

interface tws_rsp_if
   import tws_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    move_cmd;
   logic signed [POS_W-1:0] move_x;
   logic signed [POS_W-1:0] move_y;
   logic [SPD_W-1:0]        move_speed_x;
   logic [SPD_W-1:0]        move_speed_y;
   logic                    halt_cmd;
   logic                    run_done;
   logic [STATUS_W-1:0]     status;

   modport source (
      output valid, move_cmd, move_x, move_y, move_speed_x, move_speed_y,
             halt_cmd, run_done, status,
      input  ready
   );
   modport sink (
      input  valid, move_cmd, move_x, move_y, move_speed_x, move_speed_y,
             halt_cmd, run_done, status,
      output ready
   );
endinterface

// ----- design/tws_control.sv -----
`timescale 1ns / 1ps
module tws_control
   import tws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CS_EXEC;
            end
         end
         CS_EXEC: begin
            // hold until the result register is free
            if (!sts.out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

// ----- design/tws_datapath.sv -----
`timescale 1ns / 1ps
module tws_datapath
   import tws_pkg::*;
#(
   parameter int MAX_WAYPOINTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  ctl_cmd_type  cmd,
   output ctl_sts_type  sts,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int IW = $clog2(MAX_WAYPOINTS);
   localparam int CW = $clog2(MAX_WAYPOINTS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_WAYPOINTS);

   // table: positions {y, x}, speeds and limit {limit, speed_y, speed_x}
   logic [2*POS_W-1:0]             pos_mem [MAX_WAYPOINTS];
   logic [LIM_W+2*SPD_W-1:0]       sl_mem  [MAX_WAYPOINTS];
   logic [2*POS_W-1:0]             pos_rd_ff;
   logic [LIM_W+2*SPD_W-1:0]       sl_rd_ff;

   logic [OP_W-1:0]                op_ff;
   logic [ELAPSED_W-1:0]           elapsed_ff;
   logic signed [POS_W-1:0]        meas_x_ff;
   logic signed [POS_W-1:0]        meas_y_ff;
   logic                           fault_ff;

   logic [CW-1:0]                  entry_count_ff, entry_count_in;
   logic [CW-1:0]                  current_index_ff, current_index_in;
   phase_type                      phase_ff, phase_in;
   logic [LIM_W-1:0]               time_spent_ff, time_spent_in;
   logic [LIM_W-1:0]               active_limit_ff, active_limit_in;

   logic                           rsp_valid_ff;
   rsp_item_type                   rsp_item_ff, rsp_item_in;

   logic                           table_full;
   logic                           in_range;
   logic                           pos_match;
   logic [LIM_W:0]                 time_sum;
   logic [LIM_W-1:0]               time_sat;

   assign table_full = (entry_count_ff == COUNT_MAX);

   // table write on an accepted add while the table is not full, read of the current entry on every accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if ((op_type'(req_item.operation) == OP_ADD) && !table_full) begin
            pos_mem[entry_count_ff[IW-1:0]] <= {req_item.target_y, req_item.target_x};
            sl_mem[entry_count_ff[IW-1:0]]  <= {req_item.time_limit, req_item.speed_y,
                                                req_item.speed_x};
         end
         pos_rd_ff <= pos_mem[current_index_ff[IW-1:0]];
         sl_rd_ff  <= sl_mem[current_index_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_item.operation;
         elapsed_ff <= req_item.elapsed;
         meas_x_ff  <= req_item.measured_x;
         meas_y_ff  <= req_item.measured_y;
         fault_ff   <= req_item.read_fault;
      end
   end

   assign in_range  = (current_index_ff < entry_count_ff);
   assign pos_match = (pos_rd_ff[POS_W-1:0] == meas_x_ff) &&
                      (pos_rd_ff[2*POS_W-1:POS_W] == meas_y_ff);
   assign time_sum  = {1'b0, time_spent_ff} + {{(LIM_W+1-ELAPSED_W){1'b0}}, elapsed_ff};
   assign time_sat  = time_sum[LIM_W] ? {LIM_W{1'b1}} : time_sum[LIM_W-1:0];

   always_comb begin
      entry_count_in   = entry_count_ff;
      current_index_in = current_index_ff;
      phase_in         = phase_ff;
      time_spent_in    = time_spent_ff;
      active_limit_in  = active_limit_ff;
      rsp_item_in      = '0;
      unique case (op_ff)
         OP_ADD: begin
            if (table_full) begin
               rsp_item_in.status = ST_FULL;
            end else begin
               rsp_item_in.status = (entry_count_ff == '0) ? ST_OK : ST_APPENDED;
               entry_count_in     = entry_count_ff + CW'(1);
            end
         end
         OP_CLEAR: begin
            entry_count_in   = '0;
            current_index_in = '0;
            phase_in         = PH_IDLE;
         end
         OP_START: begin
            if ((phase_ff == PH_CMD) || (phase_ff == PH_WAIT)) begin
               rsp_item_in.status = ST_BUSY;
            end else begin
               current_index_in = '0;
               phase_in         = PH_CMD;
            end
         end
         OP_STOP: begin
            phase_in = PH_IDLE;
         end
         OP_POLL: begin
            unique case (phase_ff)
               PH_CMD: begin
                  if (!in_range) begin
                     phase_in             = PH_IDLE;
                     rsp_item_in.run_done = 1'b1;
                  end else begin
                     rsp_item_in.move_cmd     = 1'b1;
                     rsp_item_in.move_x       = pos_rd_ff[POS_W-1:0];
                     rsp_item_in.move_y       = pos_rd_ff[2*POS_W-1:POS_W];
                     rsp_item_in.move_speed_x = sl_rd_ff[SPD_W-1:0];
                     rsp_item_in.move_speed_y = sl_rd_ff[2*SPD_W-1:SPD_W];
                     active_limit_in          = sl_rd_ff[LIM_W+2*SPD_W-1:2*SPD_W];
                     time_spent_in            = '0;
                     phase_in                 = PH_WAIT;
                  end
               end
               PH_WAIT: begin
                  if (fault_ff) begin
                     phase_in           = PH_CMD;
                     rsp_item_in.status = ST_FAULT;
                  end else if (!in_range) begin
                     phase_in = PH_CMD;
                  end else if (pos_match) begin
                     current_index_in = current_index_ff + CW'(1);
                     phase_in         = PH_CMD;
                  end else begin
                     time_spent_in = time_sat;
                     if (time_sat >= active_limit_ff) begin
                        current_index_in     = current_index_ff + CW'(1);
                        phase_in             = PH_CMD;
                        rsp_item_in.halt_cmd = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff   <= '0;
         current_index_ff <= '0;
         phase_ff         <= PH_IDLE;
         time_spent_ff    <= '0;
         active_limit_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (cmd.commit) begin
            entry_count_ff   <= entry_count_in;
            current_index_ff <= current_index_in;
            phase_ff         <= phase_in;
            time_spent_ff    <= time_spent_in;
            active_limit_ff  <= active_limit_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff     <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign sts.out_blocked = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_item_ff;

endmodule

// ----- design/two_axis_waypoint_sequencer.sv -----
// Two-axis waypoint sequencer.
// req_chan carries one request transaction: add a waypoint, clear the table,
// start a run, stop it, or a poll tick with elapsed time and measured positions.
// rsp_chan returns exactly one response transaction for every request: move or
// halt command, run done flag and a status code.
// A request is accepted while the controller is idle, and the waypoint table is read into a
// register at that edge; then, in the execute state, the response is loaded into the output
// register. No new request is taken until that execute step is done, since the registered
// read of the table memory is followed by the compare and update.
// req_chan.ready is high only while the controller is idle; a result waiting in
// the output register does not keep the next request out.
// When the receiver stalls, the response holds in the output register and the
// following request waits in its execute cycle until that register drains.
// Reset (synchronous, active high) empties the table, ends any run and drops a
// pending response. Table contents are not cleared; entries are only read once
// written. MAX_WAYPOINTS sets the table depth.
`timescale 1ns / 1ps
`include "two_axis_waypoint_sequencer_macros.svh"
module two_axis_waypoint_sequencer
   import tws_pkg::*;
#(
   parameter int MAX_WAYPOINTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   tws_req_if.sink    req_chan,
   tws_rsp_if.source  rsp_chan
);

   ctl_cmd_type  cmd;
   ctl_sts_type  sts;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         req_ready;
   logic         rsp_valid;

   // pack the request fields for the datapath
   assign req_item.operation  = req_chan.operation;
   assign req_item.target_x   = req_chan.target_x;
   assign req_item.target_y   = req_chan.target_y;
   assign req_item.speed_x    = req_chan.speed_x;
   assign req_item.speed_y    = req_chan.speed_y;
   assign req_item.time_limit = req_chan.time_limit;
   assign req_item.elapsed    = req_chan.elapsed;
   assign req_item.measured_x = req_chan.measured_x;
   assign req_item.measured_y = req_chan.measured_y;
   assign req_item.read_fault = req_chan.read_fault;

   assign req_chan.ready = req_ready;

   // sequencing: accept, then execute and load the response register
   tws_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // waypoint table, run state and response register
   tws_datapath #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   // drive the response transaction
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.move_cmd     = rsp_item.move_cmd;
   assign rsp_chan.move_x       = rsp_item.move_x;
   assign rsp_chan.move_y       = rsp_item.move_y;
   assign rsp_chan.move_speed_x = rsp_item.move_speed_x;
   assign rsp_chan.move_speed_y = rsp_item.move_speed_y;
   assign rsp_chan.halt_cmd     = rsp_item.halt_cmd;
   assign rsp_chan.run_done     = rsp_item.run_done;
   assign rsp_chan.status       = rsp_item.status;

   // an accepted request always occupies the next cycle
   `TWS_ASSERT_NEXT(a_busy_after_load, clock, reset, cmd.load, !req_chan.ready)
   // every execute step shows up as a response
   `TWS_ASSERT_NEXT(a_commit_gives_rsp, clock, reset, cmd.commit, rsp_chan.valid)
   // a stalled response is never overwritten
   `TWS_ASSERT_SAME(a_no_overwrite, clock, reset,
                    rsp_chan.valid && !rsp_chan.ready, !cmd.commit)

endmodule
